// ===== hdl/csplit_pkg.sv =====
// Shared types, constants and helpers for the command line splitter.
// Used by every module of the block; no dependencies of its own.
package csplit_pkg;

  // Storage widths
  localparam int OFFSET_BITS = 16;
  localparam int COUNT_BITS  = 8;
  localparam int RUN_BITS    = 16;

  // Field widths on the channels
  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 3;
  localparam int REPEAT_W = 16;
  localparam int OFFSET_W = 16;
  localparam int INDEX_W  = 8;
  localparam int MAXARG_W = 9;
  localparam int CAP_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Results one item can cause
  localparam int MAX_RES = 3;
  localparam int RES_CNT_W = 2;

  // Compare widths, wide enough that no sum can wrap
  localparam int SUM_W = ((OFFSET_BITS > CAP_W) ? OFFSET_BITS : CAP_W) + 2;
  localparam int ARG_W = ((COUNT_BITS > MAXARG_W) ? COUNT_BITS : MAXARG_W) + 2;

  localparam logic [SUM_W-1:0]    CAP_MAX  = (SUM_W'(1) << OFFSET_BITS) - SUM_W'(1);
  localparam logic [ARG_W-1:0]    ARG_MAX  = ARG_W'(1) << COUNT_BITS;
  localparam logic [RUN_BITS-1:0] RUN_MAX  = '1;

  localparam logic [MAXARG_W-1:0] MAX_ARGS_RST  = MAXARG_W'(256);
  localparam logic [CAP_W-1:0]    STORE_CAP_RST = '1;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ARGS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_CAP = 1'b1;

  // Characters with a meaning
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;

  typedef enum logic [KIND_W-1:0] {
    KIND_START = 3'd0,
    KIND_RUN   = 3'd1,
    KIND_END   = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [CHAR_W-1:0]     out_byte;
    logic [REPEAT_W-1:0]   repeat_count;
    logic [OFFSET_W-1:0]   store_offset;
    logic [INDEX_W-1:0]    arg_index;
  } result_t;

  typedef result_t res_arr_t [MAX_RES];

  typedef struct packed {
    logic                   in_quote;
    logic                   in_argument;
    logic [RUN_BITS-1:0]    backslash_run;
    logic [OFFSET_BITS-1:0] write_offset;
    logic [COUNT_BITS-1:0]  argument_count;
    logic                   error_seen;
  } state_t;

  typedef struct packed {
    logic [SUM_W-1:0] cap;
    logic [ARG_W-1:0] args;
  } limits_t;

  function automatic result_t mk_res(kind_e k, logic [CHAR_W-1:0] b,
                                     logic [RUN_BITS-1:0] cnt,
                                     logic [SUM_W-1:0] off,
                                     logic [COUNT_BITS-1:0] idx);
    result_t r;
    r.kind         = k;
    r.out_byte     = b;
    r.repeat_count = REPEAT_W'(cnt);
    r.store_offset = OFFSET_W'(off);
    r.arg_index    = INDEX_W'(idx);
    return r;
  endfunction

endpackage

// ===== hdl/csplit_in_if.sv =====
// Input channel of the splitter: one command line byte or the end marker.
// Depends on csplit_pkg.
interface csplit_in_if;
  import csplit_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              end_of_line;

  modport source (output valid, char_in, end_of_line, input ready);
  modport sink   (input valid, char_in, end_of_line, output ready);
endinterface

// ===== hdl/csplit_out_if.sv =====
// Result channel of the splitter: one store event per beat.
// Depends on csplit_pkg.
interface csplit_out_if;
  import csplit_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CHAR_W-1:0]   out_byte;
  logic [REPEAT_W-1:0] repeat_count;
  logic [OFFSET_W-1:0] store_offset;
  logic [INDEX_W-1:0]  arg_index;
  logic                last;

  modport source (output valid, kind, out_byte, repeat_count, store_offset, arg_index,
                  last, input ready);
  modport sink   (input valid, kind, out_byte, repeat_count, store_offset, arg_index,
                  last, output ready);
endinterface

// ===== hdl/csplit_cfg_if.sv =====
// Configuration write channel of the splitter: register index and data.
// Depends on csplit_pkg.
interface csplit_cfg_if;
  import csplit_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/csplit_cfg_regs.sv =====
// Configuration registers (argument limit, store capacity) and the
// effective limits derived from them. Depends on csplit_pkg, csplit_cfg_if.
module csplit_cfg_regs
  import csplit_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  csplit_cfg_if.sink    cfg_i,
  output limits_t       limits_o
);

  logic [MAXARG_W-1:0] max_args_q;
  logic [CAP_W-1:0]    store_cap_q;

  assign cfg_i.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_args_q  <= MAX_ARGS_RST;
      store_cap_q <= STORE_CAP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MAX_ARGS:  max_args_q  <= cfg_i.data[MAXARG_W-1:0];
        REG_STORE_CAP: store_cap_q <= cfg_i.data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clip to what the offset and count registers can hold
  always_comb begin
    limits_o.cap  = (SUM_W'(store_cap_q) < CAP_MAX) ? SUM_W'(store_cap_q) : CAP_MAX;
    limits_o.args = (ARG_W'(max_args_q) < ARG_MAX) ? ARG_W'(max_args_q) : ARG_MAX;
  end

endmodule

// ===== hdl/csplit_step.sv =====
// Per-byte splitting logic: from the current line state and one input
// item, the next state and up to three results. Depends on csplit_pkg.
module csplit_step
  import csplit_pkg::*;
(
  input  state_t               st_i,
  input  logic [CHAR_W-1:0]    char_i,
  input  logic                 eol_i,
  input  limits_t              limits_i,
  output state_t               nx_o,
  output res_arr_t             res_o,
  output logic [RES_CNT_W-1:0] n_o
);

  logic [SUM_W-1:0]      wo;
  logic [COUNT_BITS-1:0] ac;
  logic [RUN_BITS-1:0]   bs;
  logic [RUN_BITS-1:0]   k;
  logic                  sep;
  logic                  ok;
  logic                  go;

  always_comb begin
    nx_o  = st_i;
    res_o = '{default: '0};
    n_o   = '0;
    wo    = SUM_W'(st_i.write_offset);
    ac    = st_i.argument_count;
    bs    = '0;
    k     = '0;
    ok    = 1'b1;
    go    = 1'b0;
    sep   = (char_i == CH_SPACE) || (char_i == CH_TAB);

    if (eol_i) begin
      // End of line: flush backslashes, close the argument, report
      if (st_i.error_seen) begin
        res_o[n_o] = mk_res(KIND_ERROR, '0, '0, wo, ac);
        n_o = n_o + 1'b1;
      end else begin
        if (st_i.in_argument) begin
          k = st_i.backslash_run;
          if (k != '0) begin
            if (wo + SUM_W'(k) >= limits_i.cap) begin
              res_o[n_o] = mk_res(KIND_ERROR, '0, '0, wo, ac);
              n_o = n_o + 1'b1;
              ok  = 1'b0;
            end else begin
              res_o[n_o] = mk_res(KIND_RUN, CH_BSLASH, k, wo, ac - 1'b1);
              n_o = n_o + 1'b1;
              wo  = wo + SUM_W'(k);
            end
          end
          if (ok) begin
            if (wo + SUM_W'(1) > limits_i.cap) begin
              res_o[n_o] = mk_res(KIND_ERROR, '0, '0, wo, ac);
              n_o = n_o + 1'b1;
              ok  = 1'b0;
            end else begin
              res_o[n_o] = mk_res(KIND_END, '0, RUN_BITS'(1), wo, ac - 1'b1);
              n_o = n_o + 1'b1;
              wo  = wo + SUM_W'(1);
            end
          end
        end
        if (ok) begin
          res_o[n_o] = mk_res(KIND_DONE, '0, '0, wo, ac);
          n_o = n_o + 1'b1;
        end
      end
      nx_o = '0;
    end else if (!st_i.error_seen && !(!st_i.in_argument && sep)) begin
      go = 1'b1;
      // Opening a new argument
      if (!st_i.in_argument) begin
        if (ARG_W'(ac) + ARG_W'(1) >= limits_i.args) begin
          res_o[n_o] = mk_res(KIND_ERROR, '0, '0, wo, ac);
          n_o = n_o + 1'b1;
          nx_o.error_seen = 1'b1;
          go = 1'b0;
        end else begin
          res_o[n_o] = mk_res(KIND_START, '0, '0, wo, ac);
          n_o = n_o + 1'b1;
          ac  = ac + 1'b1;
          nx_o.in_argument   = 1'b1;
          nx_o.in_quote      = 1'b0;
          nx_o.backslash_run = '0;
        end
      end

      if (go) begin
        if (char_i == CH_BSLASH) begin
          // Saturating backslash count
          if (nx_o.backslash_run != RUN_MAX) begin
            nx_o.backslash_run = nx_o.backslash_run + 1'b1;
          end
        end else begin
          bs = nx_o.backslash_run;
          nx_o.backslash_run = '0;
          // Pending backslashes: halved before a quote, literal otherwise
          k = (char_i == CH_QUOTE) ? (bs >> 1) : bs;
          if (k != '0) begin
            if (wo + SUM_W'(k) >= limits_i.cap) begin
              res_o[n_o] = mk_res(KIND_ERROR, '0, '0, wo, ac);
              n_o = n_o + 1'b1;
              nx_o.error_seen = 1'b1;
              ok = 1'b0;
            end else begin
              res_o[n_o] = mk_res(KIND_RUN, CH_BSLASH, k, wo, ac - 1'b1);
              n_o = n_o + 1'b1;
              wo  = wo + SUM_W'(k);
            end
          end
          if (ok) begin
            if (char_i == CH_QUOTE && !bs[0]) begin
              nx_o.in_quote = !nx_o.in_quote;
            end else if (char_i == CH_QUOTE || nx_o.in_quote || !sep) begin
              // One literal byte (escaped quote, quoted separator or ordinary character)
              if (wo + SUM_W'(1) >= limits_i.cap) begin
                res_o[n_o] = mk_res(KIND_ERROR, '0, '0, wo, ac);
                n_o = n_o + 1'b1;
                nx_o.error_seen = 1'b1;
              end else begin
                res_o[n_o] = mk_res(KIND_RUN, char_i, RUN_BITS'(1), wo, ac - 1'b1);
                n_o = n_o + 1'b1;
                wo  = wo + SUM_W'(1);
              end
            end else begin
              // Unquoted separator closes the argument
              if (wo + SUM_W'(1) > limits_i.cap) begin
                res_o[n_o] = mk_res(KIND_ERROR, '0, '0, wo, ac);
                n_o = n_o + 1'b1;
                nx_o.error_seen = 1'b1;
              end else begin
                res_o[n_o] = mk_res(KIND_END, '0, RUN_BITS'(1), wo, ac - 1'b1);
                n_o = n_o + 1'b1;
                wo  = wo + SUM_W'(1);
                nx_o.in_argument = 1'b0;
                nx_o.in_quote    = 1'b0;
              end
            end
          end
        end
      end

      // An error drops the argument in progress
      if (nx_o.error_seen) begin
        nx_o.in_quote      = 1'b0;
        nx_o.in_argument   = 1'b0;
        nx_o.backslash_run = '0;
      end
      nx_o.write_offset   = OFFSET_BITS'(wo);
      nx_o.argument_count = ac;
    end
  end

endmodule

// ===== hdl/csplit_res_buf.sv =====
// Result register: holds the results of one item and hands them out one
// beat at a time, marking the final one. Depends on csplit_pkg, csplit_out_if.
module csplit_res_buf
  import csplit_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  res_arr_t             res_i,
  input  logic [RES_CNT_W-1:0] n_i,
  output logic                 free_o,
  csplit_out_if.source         out_o
);

  res_arr_t             res_q;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic [RES_CNT_W-1:0] head_q, head_d;
  logic                 pop;
  result_t              cur;

  assign pop    = out_o.valid && out_o.ready;
  // Free when empty or when its final beat leaves this cycle
  assign free_o = (cnt_q == '0) || (pop && cnt_q == RES_CNT_W'(1));

  assign cur                = res_q[head_q];
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.kind         = cur.kind;
  assign out_o.out_byte     = cur.out_byte;
  assign out_o.repeat_count = cur.repeat_count;
  assign out_o.store_offset = cur.store_offset;
  assign out_o.arg_index    = cur.arg_index;
  assign out_o.last         = (cnt_q == RES_CNT_W'(1));

  // Count and read pointer
  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (load_i) begin
      cnt_d  = n_i;
      head_d = '0;
    end else if (pop) begin
      cnt_d  = cnt_q - 1'b1;
      head_d = head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hdl/command_line_splitter_core.sv =====
// Command line splitter, top level: input register, line state, step logic
// and result register. Depends on csplit_pkg, the channel interfaces and submodules.
//
// Takes a command line one byte per input beat, closed by a beat with
// end_of_line set, and reports what goes into the argument store: argument
// starts, backslash and byte runs, terminators, and a final done (or error)
// carrying the byte and argument counts. One byte is accepted every clock
// cycle as long as it causes at most one result and the result channel is
// not stalled; a byte that causes two or three results keeps the result
// register until they have all left and stalls the input meanwhile, because
// the result channel carries one result per beat. An accepted byte passes
// the input register, then the result register, before its first result.
// After an end-of-line beat all line state is back at its reset values.
// Configuration must be written only while the block is idle; the block itself does not enforce it.
module command_line_splitter_core
  import csplit_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  csplit_in_if.sink    item_i,
  csplit_out_if.source result_o,
  csplit_cfg_if.sink   cfg_i
);

  limits_t              limits;
  state_t               state_q, state_nx;
  res_arr_t             res;
  logic [RES_CNT_W-1:0] res_n;
  logic                 buf_free;
  logic                 advance;

  logic                 in_valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 eol_q;

  csplit_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .limits_o (limits)
  );

  // Registered item moves on when the result register can take its results
  assign advance      = in_valid_q && buf_free;
  assign item_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      char_q <= item_i.char_in;
      eol_q  <= item_i.end_of_line;
    end
  end

  csplit_step u_step (
    .st_i     (state_q),
    .char_i   (char_q),
    .eol_i    (eol_q),
    .limits_i (limits),
    .nx_o     (state_nx),
    .res_o    (res),
    .n_o      (res_n)
  );

  // Line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_nx;
    end
  end

  csplit_res_buf u_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .res_i  (res),
    .n_i    (res_n),
    .free_o (buf_free),
    .out_o  (result_o)
  );

endmodule

// ===== hdl/csplit_checker.sv =====
// Port-level checks on the result channel of the splitter, bound to the
// top level. Depends on csplit_pkg and command_line_splitter_core.
module csplit_checker
  import csplit_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid,
  input logic                out_ready,
  input logic [KIND_W-1:0]   out_kind,
  input logic [CHAR_W-1:0]   out_byte,
  input logic [REPEAT_W-1:0] out_repeat,
  input logic                out_last
);

  // Done and error always close the results of their item
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_DONE || out_kind == KIND_ERROR) |-> out_last)
    else $error("done/error result without last");

  // A terminator writes exactly one zero byte
  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_END |-> out_repeat == REPEAT_W'(1) && out_byte == '0)
    else $error("terminator with wrong byte or count");

  // Empty runs are never reported
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_RUN |-> out_repeat != '0)
    else $error("byte run of zero length");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind command_line_splitter_core csplit_checker u_csplit_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (result_o.valid),
  .out_ready  (result_o.ready),
  .out_kind   (result_o.kind),
  .out_byte   (result_o.out_byte),
  .out_repeat (result_o.repeat_count),
  .out_last   (result_o.last)
);

// ===== tb/tb_command_line_splitter_core.sv =====
// Self-checking testbench for command_line_splitter_core: directed and random command lines,
// register settings across a range of limits, results checked against a predictor of the store.
// Depends on csplit_pkg and the csplit_in_if, csplit_out_if and csplit_cfg_if interfaces.
module tb_command_line_splitter_core;
  import csplit_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;   // cycles with no beat on any channel
  localparam int unsigned SETTLE_CYCLES = 6;    // pipeline depth plus margin

  // Opening line set: {end_of_line, char_in}
  localparam logic [8:0] OPENING [25] = '{
    {1'b1, 8'hFF},                                 // empty line, byte ignored
    {1'b0, CH_SPACE}, {1'b0, CH_TAB},              // leading separators
    {1'b0, 8'h00}, {1'b0, 8'h61},                  // zero byte opens an argument
    {1'b0, CH_BSLASH}, {1'b0, CH_BSLASH}, {1'b0, CH_QUOTE},  // even run, opens quote
    {1'b0, CH_SPACE}, {1'b0, 8'h78}, {1'b0, CH_QUOTE},       // quoted space, close
    {1'b0, CH_SPACE},                              // argument end
    {1'b0, CH_QUOTE}, {1'b0, CH_TAB},              // quoted tab
    {1'b0, CH_BSLASH}, {1'b0, CH_BSLASH}, {1'b0, CH_BSLASH},
    {1'b0, CH_QUOTE},                              // odd run, literal quote
    {1'b0, 8'hFF}, {1'b0, CH_BSLASH}, {1'b0, CH_SPACE},      // lone backslash is literal
    {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE},            // close and reopen
    {1'b0, CH_BSLASH},
    {1'b1, 8'h00}                                  // flush, terminate, unclosed quote
  };

  typedef struct packed {
    result_t res;
    logic    last;
  } store_event_t;

  // Predicts the store events of each accepted beat and checks what comes out
  class arg_store_model;
    logic [MAXARG_W-1:0] max_args;
    logic [CAP_W-1:0]    store_cap;
    bit                  in_quote;
    bit                  in_arg;
    bit                  err_seen;
    int unsigned         bs_run;
    int unsigned         wr_off;
    int unsigned         argc;
    int unsigned         n_step;
    store_event_t        pending[$];
    int unsigned         errors;
    int unsigned         checked;

    function new();
      max_args  = MAX_ARGS_RST;
      store_cap = STORE_CAP_RST;
      errors    = 0;
      checked   = 0;
      clear_line();
    endfunction

    function void clear_line();
      in_quote = 1'b0;
      in_arg   = 1'b0;
      err_seen = 1'b0;
      bs_run   = 0;
      wr_off   = 0;
      argc     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_MAX_ARGS) begin
        max_args = d[MAXARG_W-1:0];
      end else begin
        store_cap = d[CAP_W-1:0];
      end
    endfunction

    function int unsigned arg_limit();
      return (max_args < 256) ? max_args : 256;
    endfunction

    function void push(kind_e k, logic [CHAR_W-1:0] b, int unsigned cnt,
                       int unsigned off, int unsigned idx);
      store_event_t e;
      e.res.kind         = k;
      e.res.out_byte     = b;
      e.res.repeat_count = REPEAT_W'(cnt);
      e.res.store_offset = OFFSET_W'(off);
      e.res.arg_index    = INDEX_W'(idx);
      e.last             = 1'b0;
      pending.push_back(e);
      n_step++;
    endfunction

    function void fail();
      push(KIND_ERROR, 8'h00, 0, wr_off, argc);
      err_seen = 1'b1;
      in_quote = 1'b0;
      in_arg   = 1'b0;
      bs_run   = 0;
    endfunction

    // k copies of b; zero-length runs are silent
    function bit put_run(logic [CHAR_W-1:0] b, int unsigned k);
      if (k == 0) return 1'b1;
      if (wr_off + k >= store_cap) begin
        fail();
        return 1'b0;
      end
      push(KIND_RUN, b, k, wr_off, argc - 1);
      wr_off += k;
      return 1'b1;
    endfunction

    function bit put_term();
      if (wr_off + 1 > store_cap) begin
        fail();
        return 1'b0;
      end
      push(KIND_END, 8'h00, 1, wr_off, argc - 1);
      wr_off   += 1;
      in_arg   = 1'b0;
      in_quote = 1'b0;
      return 1'b1;
    endfunction

    function void mark_last();
      if (n_step > 0) pending[pending.size()-1].last = 1'b1;
    endfunction

    // Note one accepted input beat
    function void take_byte(logic [CHAR_W-1:0] c, bit eol);
      bit          sep;
      bit          ok;
      int unsigned bs;
      sep    = (c == CH_SPACE) || (c == CH_TAB);
      n_step = 0;
      if (eol) begin
        if (err_seen) begin
          fail();
        end else begin
          ok = 1'b1;
          if (in_arg) begin
            ok = put_run(CH_BSLASH, bs_run);
            if (ok) ok = put_term();
          end
          if (ok) push(KIND_DONE, 8'h00, 0, wr_off, argc);
        end
        clear_line();
        mark_last();
        return;
      end
      if (err_seen) return;
      if (!in_arg) begin
        if (sep) return;
        if (argc + 1 >= arg_limit()) begin
          fail();
          mark_last();
          return;
        end
        push(KIND_START, 8'h00, 0, wr_off, argc);
        argc++;
        in_arg   = 1'b1;
        in_quote = 1'b0;
        bs_run   = 0;
      end
      if (c == CH_BSLASH) begin
        if (bs_run < RUN_MAX) bs_run++;
      end else if (c == CH_QUOTE) begin
        bs     = bs_run;
        bs_run = 0;
        if (put_run(CH_BSLASH, bs / 2)) begin
          if (bs[0]) void'(put_run(CH_QUOTE, 1));
          else in_quote = !in_quote;
        end
      end else begin
        bs     = bs_run;
        bs_run = 0;
        if (put_run(CH_BSLASH, bs)) begin
          if (in_quote || !sep) void'(put_run(c, 1));
          else void'(put_term());
        end
      end
      mark_last();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one result beat with the oldest prediction
    task match_event(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] b,
                     logic [REPEAT_W-1:0] cnt, logic [OFFSET_W-1:0] off,
                     logic [INDEX_W-1:0] idx, logic last);
      store_event_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d: kind %0d at offset %0d with nothing predicted",
                         checked, kind, off));
        return;
      end
      want = pending.pop_front();
      if (kind !== want.res.kind)
        report($sformatf("result %0d: kind %0d, want %0d", checked, kind, want.res.kind));
      if (b !== want.res.out_byte)
        report($sformatf("result %0d: out_byte %h, want %h", checked, b, want.res.out_byte));
      if (cnt !== want.res.repeat_count)
        report($sformatf("result %0d: repeat_count %0d, want %0d", checked, cnt,
                         want.res.repeat_count));
      if (off !== want.res.store_offset)
        report($sformatf("result %0d: store_offset %0d, want %0d", checked, off,
                         want.res.store_offset));
      if (idx !== want.res.arg_index)
        report($sformatf("result %0d: arg_index %0d, want %0d", checked, idx,
                         want.res.arg_index));
      if (last !== want.last)
        report($sformatf("result %0d: last %b, want %b", checked, last, want.last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  csplit_in_if  item_if();
  csplit_out_if res_if();
  csplit_cfg_if cfg_if();

  command_line_splitter_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  arg_store_model store_model = new();
  bit             idle_on;
  int unsigned    items_sent;
  int unsigned    lines_sent;
  int unsigned    reg_writes;
  int unsigned    quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One input beat, optionally preceded by an idle burst
  task automatic send_beat(logic [CHAR_W-1:0] c, bit eol);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.char_in     <= c;
    item_if.end_of_line <= eol;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    store_model.take_byte(c, eol);
    items_sent++;
  endtask

  // Mostly meaningful characters, some arbitrary bytes
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return CHAR_W'($urandom_range(8'h61, 8'h7A));
    else if (r < 50) return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
    else if (r < 68) return CH_BSLASH;
    else if (r < 82) return CH_QUOTE;
    else return CHAR_W'($urandom);
  endfunction

  task automatic send_line(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_beat(pick_char(), 1'b0);
    send_beat(CHAR_W'($urandom), 1'b1);
    lines_sent++;
  endtask

  // Wait until the block is idle, then write both registers back to back
  task automatic configure(logic [CFG_DATA_W-1:0] n_args, logic [CFG_DATA_W-1:0] cap);
    item_if.valid <= 1'b0;
    while (store_model.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_MAX_ARGS;
    cfg_if.data  <= n_args;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    store_model.set_reg(REG_MAX_ARGS, n_args);
    cfg_if.index <= REG_STORE_CAP;
    cfg_if.data  <= cap;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    store_model.set_reg(REG_STORE_CAP, cap);
    cfg_if.valid <= 1'b0;
    reg_writes += 2;
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] n_args, logic [CFG_DATA_W-1:0] cap,
                           int unsigned lines, bit idle);
    configure(n_args, cap);
    idle_on = idle;
    repeat (lines) send_line($urandom_range(0, 20));
  endtask

  // Result sink with random stall bursts
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
        store_model.match_event(res_if.kind, res_if.out_byte, res_if.repeat_count,
                                res_if.store_offset, res_if.arg_index, res_if.last);
      if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 16);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no beat on any channel
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, store_model.pending.size());
        $display("[command_line_splitter_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    item_if.valid       <= 1'b0;
    item_if.char_in     <= '0;
    item_if.end_of_line <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_MAX_ARGS;
    cfg_if.data         <= '0;
    rst_ni              <= 1'b0;
    quiet_cycles        = 0;
    items_sent          = 0;
    lines_sent          = 0;
    reg_writes          = 0;
    idle_on             = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-picked lines under reset settings
    foreach (OPENING[i]) send_beat(OPENING[i][7:0], OPENING[i][8]);

    // Random lines under a range of limits
    run_phase(16'd256, 16'hFFFF, 8, 1'b1);
    run_phase(16'd3,   16'd40,   5, 1'b1);
    run_phase(16'd1,   16'hFFFF, 3, 1'b1);
    run_phase(16'd0,   16'd0,    2, 1'b1);
    run_phase(16'd511, 16'd20,   4, 1'b1);
    run_phase(16'd2,   16'd1,    3, 1'b1);

    // Closing stretch without idling
    run_phase(16'd5, 16'd300, 5, 1'b0);

    item_if.valid <= 1'b0;
    while (store_model.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);

    $display("run covered %0d input beats in %0d lines and %0d register writes;",
             items_sent, lines_sent, reg_writes);
    $display("%0d results checked, %0d mismatches", store_model.checked, store_model.errors);
    if (store_model.errors == 0) begin
      $display("[command_line_splitter_core] OK");
    end else begin
      $display("[command_line_splitter_core] ERROR");
    end
    $finish;
  end

endmodule
